[hdl/slc_pkg.sv]
// Shared types, constants and codes for the set-associative LRU write-back cache.
package slc_pkg;

  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_MAX_SETS = 1024;
  localparam int DEF_TAG_BITS = 28;

  localparam int VICTIM_W   = 28;
  localparam int ADDR_W     = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 2'd2;

  localparam logic [2:0] OB_MIN     = 3'd4;
  localparam logic [2:0] OB_MAX     = 3'd6;
  localparam logic [2:0] OB_RESET   = 3'd4;
  localparam logic [3:0] IB_RESET   = 4'd6;
  localparam logic [3:0] WAYS_RESET = 4'd1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [2:0] block_offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic                writeback;
    logic [VICTIM_W-1:0] victim_block;
  } result_t;

endpackage

[hdl/slc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/slc_ctrl.sv]
// Sequencer: clear, set read, way-by-way tag compare, LRU reorder and set write.
module slc_ctrl import slc_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic                                         in_cmd,
  input  logic [ADDR_W-1:0]                            in_addr,
  input  cfg_t                                         cfg,
  output logic                                         res_valid,
  input  logic                                         res_ready,
  output result_t                                      res,
  output logic                                         mem_wr_en,
  output logic [$clog2(MAX_SETS > 1 ? MAX_SETS : 2)-1:0] mem_wr_addr,
  output logic [MAX_WAYS*(TAG_BITS+2)-1:0]             mem_wr_data,
  output logic                                         mem_rd_en,
  output logic [$clog2(MAX_SETS > 1 ? MAX_SETS : 2)-1:0] mem_rd_addr,
  input  logic [MAX_WAYS*(TAG_BITS+2)-1:0]             mem_rd_data
);

  localparam int MIB    = $clog2(MAX_SETS + 1) - 1;
  localparam int AW     = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
  localparam int PW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW    = $clog2(MAX_WAYS + 1);
  localparam int LINE_W = TAG_BITS + 2;
  localparam int V_BIT  = LINE_W - 1;
  localparam int D_BIT  = LINE_W - 2;

  state_t state, state_next;
  logic [AW-1:0] clr_cnt;

  logic [2:0]          ob_sat;
  logic [3:0]          ib_sat;
  logic [WCW-1:0]      w_sat;
  logic [ADDR_W-1:0]   blk;
  logic [ADDR_W-1:0]   set_mask;
  logic [ADDR_W-1:0]   tag_wide;

  logic                cmd_q;
  logic [AW-1:0]       set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [3:0]          ib_q;
  logic [WCW-1:0]      w_q;
  logic [PW-1:0]       pos;
  logic [WCW-1:0]      n_cnt;
  logic                found;
  logic [PW-1:0]       hit_pos;

  logic [MAX_WAYS-1:0][LINE_W-1:0] row, row_up, row_new;
  logic [LINE_W-1:0]   way_cur;
  logic                way_valid, tag_eq, pos_last;

  logic                full, new_dirty;
  logic [PW-1:0]       lo, hi;
  logic [LINE_W-1:0]   new_line;
  logic [63:0]         vwide;

  always_comb begin
    if (cfg.block_offset_bits < OB_MIN) begin
      ob_sat = OB_MIN;
    end else if (cfg.block_offset_bits > OB_MAX) begin
      ob_sat = OB_MAX;
    end else begin
      ob_sat = cfg.block_offset_bits;
    end
    if (int'(cfg.index_bits) > MIB) begin
      ib_sat = 4'(MIB);
    end else begin
      ib_sat = cfg.index_bits;
    end
    if (cfg.ways_in_use == 4'd0) begin
      w_sat = WCW'(1);
    end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
      w_sat = WCW'(MAX_WAYS);
    end else begin
      w_sat = WCW'(cfg.ways_in_use);
    end
  end

  assign blk      = in_addr >> ob_sat;
  assign set_mask = (ADDR_W'(1) << ib_sat) - ADDR_W'(1);
  assign tag_wide = blk >> ib_sat;

  // shared tag compare on the way under the scan pointer
  assign row       = mem_rd_data;
  assign way_cur   = row[pos];
  assign way_valid = way_cur[V_BIT];
  assign tag_eq    = (way_cur[TAG_BITS-1:0] == tag_q);
  assign pos_last  = ((WCW'(pos) + WCW'(1)) == w_q);

  assign row_up = row >> LINE_W;

  always_comb begin
    full = (n_cnt == w_q);
    if (found) begin
      lo        = hit_pos;
      hi        = PW'(n_cnt - WCW'(1));
      new_dirty = row[hit_pos][D_BIT] | (cmd_q == CMD_WRITE);
    end else if (!full) begin
      lo        = PW'(n_cnt);
      hi        = PW'(n_cnt);
      new_dirty = 1'b0;
    end else begin
      lo        = '0;
      hi        = PW'(n_cnt - WCW'(1));
      new_dirty = 1'b0;
    end
    new_line = {1'b1, new_dirty, tag_q};
    for (int q = 0; q < MAX_WAYS; q++) begin
      if (q == int'(hi)) begin
        row_new[q] = new_line;
      end else if (q >= int'(lo) && q < int'(hi)) begin
        row_new[q] = row_up[q];
      end else begin
        row_new[q] = row[q];
      end
    end
    vwide = (64'(row[0][TAG_BITS-1:0]) << ib_q) | 64'(set_q);
    res.hit          = found;
    res.evicted      = !found && full;
    res.writeback    = !found && full && row[0][D_BIT];
    res.victim_block = (!found && full) ? VICTIM_W'(vwide) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_q <= in_cmd;
          set_q <= AW'(blk & set_mask);
          tag_q <= TAG_BITS'(tag_wide);
          ib_q  <= ib_sat;
          w_q   <= w_sat;
        end
      end
      ST_READ: begin
        pos   <= '0;
        n_cnt <= '0;
        found <= 1'b0;
      end
      ST_SCAN: begin
        if (way_valid) begin
          n_cnt <= WCW'(pos) + WCW'(1);
          if (!found && tag_eq) begin
            found   <= 1'b1;
            hit_pos <= pos;
          end
        end
        pos <= pos + PW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = set_q;
    mem_wr_data = row_new;
    mem_rd_en   = 1'b0;
    mem_rd_addr = set_q;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt;
        mem_wr_data = '0;
        if (clr_cnt == AW'(MAX_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_rd_en  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!way_valid || pos_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          mem_wr_en  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/set_assoc_lru_writeback_cache.sv]
// Top level of the set-associative LRU write-back cache tag model.
//
// Requests enter on the s_axis channel: tdata carries the byte address and
// tuser the command (0 read, 1 write). One result leaves per request on the
// m_axis channel: hit, evicted, writeback and the victim block address.
// Registers are written on the cfg channel (index, data). The user is to
// write them only while the block is idle; the block itself does not
// enforce this. cfg_ready is always high. Each accepted request reads its
// set row from the set RAM, scans the ways, from one up to the ways in use,
// through the shared tag comparator until the first free way or the last
// way in use, and writes the reordered row back; the result is registered
// in the output register in the same cycle as that write. s_axis_tready
// stays low from acceptance until the row is written back. After reset a
// clearing pass zeroes every set row; s_axis_tready stays low meanwhile.
// If the receiver stalls, the result is held in the output register; a
// following request is accepted and processed, and its set update waits
// until the output register is free.
module set_assoc_lru_writeback_cache import slc_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,  // [31:0] address
  input  logic                  s_axis_tuser,  // [0] command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [0] hit, [1] evicted, [2] writeback,
                                               // [30:3] victim_block, [31] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
  localparam int ROW_W = MAX_WAYS * (TAG_BITS + 2);

  cfg_t    cfg;
  result_t res;
  logic    res_valid, res_ready;

  logic             mem_wr_en, mem_rd_en;
  logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
  logic [ROW_W-1:0] mem_wr_data, mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_offset_bits <= OB_RESET;
      cfg.index_bits        <= IB_RESET;
      cfg.ways_in_use       <= WAYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_OFFSET: cfg.block_offset_bits <= cfg_data[2:0];
        CFG_INDEX_BITS:   cfg.index_bits        <= cfg_data;
        CFG_WAYS_IN_USE:  cfg.ways_in_use       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {1'b0, res.victim_block, res.writeback, res.evicted, res.hit};
    end
  end

  slc_ctrl #(
    .MAX_WAYS(MAX_WAYS),
    .MAX_SETS(MAX_SETS),
    .TAG_BITS(TAG_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_addr    (s_axis_tdata),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  slc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_set_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

[hdl/slc_checker.sv]
// Port-level checker for the cache top level, with its bind.
module slc_checker import slc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request accepted during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while busy");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("hit reported with eviction");

  a_no_evict_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[30:2] == '0)
    else $error("writeback or victim without eviction");

endmodule

bind set_assoc_lru_writeback_cache slc_checker u_slc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
